[hw/rtl/sac_pkg.sv]
// ============================================================================
// sac_pkg: shared definitions for the set associative tag lookup
// Configuration layout, register indexes, codes, defaults, width helpers and
// the replacement LFSR step.
// ============================================================================
package sac_pkg;

    // Default geometry
    localparam int unsigned SAC_SETS        = 256;
    localparam int unsigned SAC_WAYS        = 8;
    localparam int unsigned SAC_TAG_WIDTH   = 32;
    localparam int unsigned SAC_STAMP_WIDTH = 32;

    // Fixed port widths
    localparam int unsigned ADDR_W      = 32;
    localparam int unsigned COUNT_W     = 32;
    localparam int unsigned OUT_WAY_W   = 3;
    localparam int unsigned OUT_SET_W   = 8;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned IB_W        = 5;   // holds an index bit count up to 16
    localparam int unsigned SHIFT_W     = 5;   // offset plus index, at most 31

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_BITS    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_BITS     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WAYS_IN_USE    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPLACE_POLICY = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_RANDOM_SEED    = 3'd4;

    // Configuration reset values
    localparam logic [3:0] OFFSET_RESET = 4'd6;
    localparam logic [3:0] INDEX_RESET  = 4'd8;
    localparam logic [3:0] WAYS_RESET   = 4'd8;

    // Item kinds and replacement policies
    localparam logic KIND_ACCESS   = 1'b0;
    localparam logic KIND_FLUSH    = 1'b1;
    localparam logic POLICY_LRU    = 1'b0;
    localparam logic POLICY_RANDOM = 1'b1;

    // Replacement LFSR (Galois form)
    localparam int unsigned        LFSR_W     = 16;
    localparam logic [LFSR_W-1:0]  LFSR_TAPS  = 16'hB400;
    localparam logic [LFSR_W-1:0]  SEED_RESET = 16'd44257;

    // Entries in the queue between front and back end
    localparam int unsigned QUEUE_DEPTH = 2;

    // Live configuration seen by front and back end
    typedef struct packed {
        logic [3:0] offset_bits;
        logic [3:0] index_bits;
        logic [3:0] ways_in_use;
        logic       replace_policy;
    } cfg_t;

    // Back end sequencer
    typedef enum logic {
        BK_IDLE,
        BK_LOOK
    } back_state_t;

    // Width of a set number that addresses the tag store
    function automatic int unsigned set_w(input int unsigned sets);
        set_w = (sets > 1) ? $clog2(sets) : 1;
    endfunction

    // Width of a way number
    function automatic int unsigned way_w(input int unsigned ways);
        way_w = (ways > 1) ? $clog2(ways) : 1;
    endfunction

    // Largest usable index bit count: floor(log2(sets))
    function automatic int unsigned max_ib(input int unsigned sets);
        max_ib = $clog2(sets + 1) - 1;
    endfunction

    // One LFSR advance
    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
        lfsr_step = (v >> 1) ^ (v[0] ? LFSR_TAPS : '0);
    endfunction

endpackage

[hw/rtl/sac_front.sv]
// ============================================================================
// sac_front: input side of the tag lookup
// Takes items off the input channel, splits the address into set and tag
// under the current configuration and pushes them into the work queue.
// ============================================================================
module sac_front
    import sac_pkg::*;
#(
    parameter int unsigned SETS      = SAC_SETS,
    parameter int unsigned TAG_WIDTH = SAC_TAG_WIDTH
)(
    input  cfg_t                      cfg,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      kind,
    input  logic [ADDR_W-1:0]         address,
    input  logic                      q_full,
    output logic                      q_push,
    output logic                      q_kind,
    output logic [set_w(SETS)-1:0]    q_set,
    output logic [TAG_WIDTH-1:0]      q_tag
);

    localparam int unsigned SET_W  = set_w(SETS);
    localparam int unsigned MAX_IB = max_ib(SETS);

    logic [IB_W-1:0]    ib_eff;
    logic [SHIFT_W-1:0] tag_shift;
    logic [ADDR_W-1:0]  shifted;
    logic [ADDR_W-1:0]  set_mask;
    logic [ADDR_W-1:0]  set_full;
    logic [ADDR_W-1:0]  tag_full;

    // Handshake: take an item whenever the queue has room
    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;
    assign q_kind   = kind;

    // Address split; index bits clamp to what the tag store can hold
    always_comb
    begin
        if ({1'b0, cfg.index_bits} > IB_W'(MAX_IB))
        begin
            ib_eff = IB_W'(MAX_IB);
        end
        else
        begin
            ib_eff = {1'b0, cfg.index_bits};
        end
        shifted   = address >> cfg.offset_bits;
        set_mask  = (ADDR_W'(1) << ib_eff) - ADDR_W'(1);
        set_full  = shifted & set_mask;
        tag_shift = SHIFT_W'(cfg.offset_bits) + SHIFT_W'(ib_eff);
        tag_full  = address >> tag_shift;
    end

    assign q_set = SET_W'(set_full);
    assign q_tag = TAG_WIDTH'(tag_full);

endmodule

[hw/rtl/sac_queue.sv]
// ============================================================================
// sac_queue: short work queue between front and back end
// Register based FIFO; lets the front keep accepting while the back end is
// busy with a lookup or waiting on the output channel.
// ============================================================================
module sac_queue
    import sac_pkg::*;
#(
    parameter int unsigned WIDTH = 1
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[hw/rtl/sac_back.sv]
// ============================================================================
// sac_back: lookup and replacement engine
// Reads one set row from the tag store; for an access, compares tags, picks the
// way to fill or evict, writes the row back and keeps the running totals.
// ============================================================================
module sac_back
    import sac_pkg::*;
#(
    parameter int unsigned SETS        = SAC_SETS,
    parameter int unsigned WAYS        = SAC_WAYS,
    parameter int unsigned TAG_WIDTH   = SAC_TAG_WIDTH,
    parameter int unsigned STAMP_WIDTH = SAC_STAMP_WIDTH
)(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cfg_t                    cfg,
    input  logic                    seed_load,
    input  logic [LFSR_W-1:0]       seed_value,
    input  logic                    q_empty,
    output logic                    q_pop,
    input  logic                    q_kind,
    input  logic [set_w(SETS)-1:0]  q_set,
    input  logic [TAG_WIDTH-1:0]    q_tag,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    hit,
    output logic                    replaced,
    output logic [OUT_WAY_W-1:0]    way,
    output logic [OUT_SET_W-1:0]    set_index,
    output logic [COUNT_W-1:0]      hit_count,
    output logic [COUNT_W-1:0]      miss_count,
    output logic [COUNT_W-1:0]      replacement_count
);

    localparam int unsigned SET_W   = set_w(SETS);
    localparam int unsigned WAY_W   = way_w(WAYS);
    localparam int unsigned NW_W    = $clog2(WAYS + 1);
    localparam int unsigned WAYS_P2 = 1 << $clog2(WAYS);
    localparam int unsigned PROD_W  = LFSR_W + NW_W;

    // Tag store: one row per set
    logic [WAYS-1:0][TAG_WIDTH-1:0]   tag_mem   [SETS];
    logic [WAYS-1:0][STAMP_WIDTH-1:0] stamp_mem [SETS];
    logic [WAYS-1:0]                  valid_mem [SETS];
    logic [SETS-1:0]                  row_live_reg;

    // Row read for the item in flight
    logic [WAYS-1:0][TAG_WIDTH-1:0]   rd_tag_reg;
    logic [WAYS-1:0][STAMP_WIDTH-1:0] rd_stamp_reg;
    logic [WAYS-1:0]                  rd_valid_reg;
    logic                             cur_kind_reg;
    logic [SET_W-1:0]                 cur_set_reg;
    logic [TAG_WIDTH-1:0]             cur_tag_reg;

    // Control and running state
    back_state_t                      state_reg;
    back_state_t                      state_next;
    logic [STAMP_WIDTH-1:0]           clock_reg;
    logic [LFSR_W-1:0]                lfsr_reg;
    logic [COUNT_W-1:0]               hits_reg;
    logic [COUNT_W-1:0]               misses_reg;
    logic [COUNT_W-1:0]               evict_reg;

    // Result register
    logic                             out_valid_reg;
    logic                             out_hit_reg;
    logic                             out_replaced_reg;
    logic [OUT_WAY_W-1:0]             out_way_reg;
    logic [OUT_SET_W-1:0]             out_set_reg;

    // Lookup datapath
    logic                             slot_free;
    logic                             commit;
    logic                             do_access;
    logic                             do_random;
    logic [NW_W-1:0]                  nw;
    logic [WAYS-1:0]                  in_use;
    logic [WAYS-1:0]                  eff_valid;
    logic                             hit_found;
    logic [WAY_W-1:0]                 hit_way;
    logic                             free_found;
    logic [WAY_W-1:0]                 free_way;
    logic [STAMP_WIDTH-1:0]           node_stamp [2*WAYS_P2];
    logic [WAY_W-1:0]                 node_way   [2*WAYS_P2];
    logic                             node_en    [2*WAYS_P2];
    logic [WAY_W-1:0]                 lru_way;
    logic [LFSR_W-1:0]                lfsr_new;
    logic [PROD_W-1:0]                rnd_prod;
    logic [NW_W-1:0]                  rnd_pick;
    logic [WAY_W-1:0]                 rnd_way;
    logic [WAY_W-1:0]                 sel_way;
    logic [WAYS-1:0]                  sel_vec;
    logic [STAMP_WIDTH-1:0]           clock_new;
    logic [WAYS-1:0][TAG_WIDTH-1:0]   tag_row_new;
    logic [WAYS-1:0][STAMP_WIDTH-1:0] stamp_row_new;
    logic [WAYS-1:0]                  valid_row_new;

    // Sequencer: next state
    always_comb
    begin
        case (state_reg)
            BK_IDLE: state_next = q_empty ? BK_IDLE : BK_LOOK;
            BK_LOOK: state_next = slot_free ? BK_IDLE : BK_LOOK;
            default: state_next = BK_IDLE;
        endcase
    end

    // Sequencer: outputs
    always_comb
    begin
        q_pop  = 1'b0;
        commit = 1'b0;
        case (state_reg)
            BK_IDLE: q_pop  = !q_empty;
            BK_LOOK: commit = slot_free;
            default:
            begin
                q_pop  = 1'b0;
                commit = 1'b0;
            end
        endcase
    end

    assign slot_free = !out_valid_reg || out_ready;
    assign do_access = commit && (cur_kind_reg == KIND_ACCESS);

    // Ways in use, clamped to 1..WAYS
    always_comb
    begin
        if (cfg.ways_in_use == '0)
        begin
            nw = NW_W'(1);
        end
        else if ({1'b0, cfg.ways_in_use} > 5'(WAYS))
        begin
            nw = NW_W'(WAYS);
        end
        else
        begin
            nw = NW_W'(cfg.ways_in_use);
        end
        for (int i = 0; i < WAYS; i++)
        begin
            in_use[i] = (NW_W'(i) < nw);
        end
    end

    // A set cleared by flush reads as all invalid
    assign eff_valid = row_live_reg[cur_set_reg] ? rd_valid_reg : '0;

    // Tag match and first free way, lowest way wins
    always_comb
    begin
        hit_found  = 1'b0;
        hit_way    = '0;
        free_found = 1'b0;
        free_way   = '0;
        for (int i = 0; i < WAYS; i++)
        begin
            if (!hit_found && in_use[i] && eff_valid[i] && (rd_tag_reg[i] == cur_tag_reg))
            begin
                hit_found = 1'b1;
                hit_way   = WAY_W'(i);
            end
            if (!free_found && in_use[i] && !eff_valid[i])
            begin
                free_found = 1'b1;
                free_way   = WAY_W'(i);
            end
        end
    end

    // Oldest stamp by tournament tree; equal stamps keep the lower way
    always_comb
    begin
        for (int n = 0; n < 2 * WAYS_P2; n++)
        begin
            node_stamp[n] = '0;
            node_way[n]   = '0;
            node_en[n]    = 1'b0;
        end
        for (int i = 0; i < WAYS; i++)
        begin
            node_stamp[WAYS_P2 + i] = rd_stamp_reg[i];
            node_way[WAYS_P2 + i]   = WAY_W'(i);
            node_en[WAYS_P2 + i]    = in_use[i];
        end
        for (int n = WAYS_P2 - 1; n >= 1; n--)
        begin
            if (node_en[2*n] && (!node_en[2*n+1] || (node_stamp[2*n] <= node_stamp[2*n+1])))
            begin
                node_stamp[n] = node_stamp[2*n];
                node_way[n]   = node_way[2*n];
                node_en[n]    = node_en[2*n];
            end
            else
            begin
                node_stamp[n] = node_stamp[2*n+1];
                node_way[n]   = node_way[2*n+1];
                node_en[n]    = node_en[2*n+1];
            end
        end
        lru_way = node_way[1];
    end

    // Random victim: scale the advanced LFSR into the ways in use
    always_comb
    begin
        lfsr_new = lfsr_step(lfsr_reg);
        rnd_prod = PROD_W'(lfsr_new) * PROD_W'(nw);
        rnd_pick = rnd_prod[LFSR_W +: NW_W];
        if (rnd_pick >= nw)
        begin
            rnd_pick = nw - NW_W'(1);
        end
        rnd_way = WAY_W'(rnd_pick);
    end

    // Way selection and row update
    always_comb
    begin
        if (hit_found)
        begin
            sel_way = hit_way;
        end
        else if (free_found)
        begin
            sel_way = free_way;
        end
        else if (cfg.replace_policy == POLICY_RANDOM)
        begin
            sel_way = rnd_way;
        end
        else
        begin
            sel_way = lru_way;
        end
        clock_new = clock_reg + STAMP_WIDTH'(1);
        for (int i = 0; i < WAYS; i++)
        begin
            sel_vec[i]       = (WAY_W'(i) == sel_way);
            tag_row_new[i]   = (sel_vec[i] && !hit_found) ? cur_tag_reg : rd_tag_reg[i];
            stamp_row_new[i] = sel_vec[i] ? clock_new : rd_stamp_reg[i];
        end
        valid_row_new = eff_valid | sel_vec;
    end

    assign do_random = do_access && !hit_found && !free_found
                       && (cfg.replace_policy == POLICY_RANDOM);

    // Control state and totals
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            row_live_reg  <= '0;
            clock_reg     <= '0;
            lfsr_reg      <= SEED_RESET;
            hits_reg      <= '0;
            misses_reg    <= '0;
            evict_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit && (cur_kind_reg == KIND_FLUSH))
            begin
                row_live_reg <= '0;
            end
            else if (do_access)
            begin
                row_live_reg[cur_set_reg] <= 1'b1;
            end
            if (do_access)
            begin
                clock_reg <= clock_new;
                if (hit_found)
                begin
                    hits_reg <= hits_reg + COUNT_W'(1);
                end
                else
                begin
                    misses_reg <= misses_reg + COUNT_W'(1);
                    if (!free_found)
                    begin
                        evict_reg <= evict_reg + COUNT_W'(1);
                    end
                end
            end
            if (seed_load)
            begin
                lfsr_reg <= seed_value;
            end
            else if (do_random)
            begin
                lfsr_reg <= lfsr_new;
            end
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Tag store read on pop, row write on commit
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            rd_tag_reg   <= tag_mem[q_set];
            rd_stamp_reg <= stamp_mem[q_set];
            rd_valid_reg <= valid_mem[q_set];
        end
        if (do_access)
        begin
            tag_mem[cur_set_reg]   <= tag_row_new;
            stamp_mem[cur_set_reg] <= stamp_row_new;
            valid_mem[cur_set_reg] <= valid_row_new;
        end
    end

    // Item in flight and result payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_kind_reg <= q_kind;
            cur_set_reg  <= q_set;
            cur_tag_reg  <= q_tag;
        end
        if (commit)
        begin
            if (cur_kind_reg == KIND_ACCESS)
            begin
                out_hit_reg      <= hit_found;
                out_replaced_reg <= !hit_found && !free_found;
                out_way_reg      <= OUT_WAY_W'(sel_way);
                out_set_reg      <= OUT_SET_W'(cur_set_reg);
            end
            else
            begin
                out_hit_reg      <= 1'b0;
                out_replaced_reg <= 1'b0;
                out_way_reg      <= '0;
                out_set_reg      <= '0;
            end
        end
    end

    // Totals only move on commit, so they stay stable while a result waits
    assign out_valid         = out_valid_reg;
    assign hit               = out_hit_reg;
    assign replaced          = out_replaced_reg;
    assign way               = out_way_reg;
    assign set_index         = out_set_reg;
    assign hit_count         = hits_reg;
    assign miss_count        = misses_reg;
    assign replacement_count = evict_reg;

endmodule

[hw/rtl/set_assoc_cache_tag_lookup.sv]
// ============================================================================
// set_assoc_cache_tag_lookup: tag only set associative cache lookup
// Top level: configuration registers, front end, work queue and back end.
// ============================================================================
// In the back end every item, access or flush, first has its set row read from
// the tag store; an access then has its tags compared, a way picked and the row
// written back. The back end holds one item at a time and takes no new item
// until the last one has been committed. A two entry queue behind the input and a
// result register on the output let either side stall without stopping the
// other. Flush clears the per set live bits, so there is no clearing pass after
// reset and items are accepted right away. The configuration port is always
// ready; a write to the seed index reloads the LFSR.
// ============================================================================
module set_assoc_cache_tag_lookup
    import sac_pkg::*;
#(
    parameter int unsigned SETS        = SAC_SETS,
    parameter int unsigned WAYS        = SAC_WAYS,
    parameter int unsigned TAG_WIDTH   = SAC_TAG_WIDTH,
    parameter int unsigned STAMP_WIDTH = SAC_STAMP_WIDTH
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   kind,
    input  logic [ADDR_W-1:0]      address,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   hit,
    output logic                   replaced,
    output logic [OUT_WAY_W-1:0]   way,
    output logic [OUT_SET_W-1:0]   set_index,
    output logic [COUNT_W-1:0]     hit_count,
    output logic [COUNT_W-1:0]     miss_count,
    output logic [COUNT_W-1:0]     replacement_count
);

    localparam int unsigned SET_W = set_w(SETS);
    localparam int unsigned Q_W   = 1 + SET_W + TAG_WIDTH;

    cfg_t                 cfg_reg;
    logic                 cfg_write;
    logic                 seed_load;
    logic                 q_push;
    logic                 q_pop;
    logic                 q_full;
    logic                 q_empty;
    logic                 push_kind;
    logic [SET_W-1:0]     push_set;
    logic [TAG_WIDTH-1:0] push_tag;
    logic [Q_W-1:0]       pop_data;
    logic                 pop_kind;
    logic [SET_W-1:0]     pop_set;
    logic [TAG_WIDTH-1:0] pop_tag;

    // Configuration registers
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign seed_load = cfg_write && (cfg_index == CFG_RANDOM_SEED);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.offset_bits    <= OFFSET_RESET;
            cfg_reg.index_bits     <= INDEX_RESET;
            cfg_reg.ways_in_use    <= WAYS_RESET;
            cfg_reg.replace_policy <= POLICY_LRU;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_OFFSET_BITS:    cfg_reg.offset_bits    <= cfg_data[3:0];
                CFG_INDEX_BITS:     cfg_reg.index_bits     <= cfg_data[3:0];
                CFG_WAYS_IN_USE:    cfg_reg.ways_in_use    <= cfg_data[3:0];
                CFG_REPLACE_POLICY: cfg_reg.replace_policy <= cfg_data[0];
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    // Front end: accept and split the address
    sac_front #(
        .SETS      (SETS),
        .TAG_WIDTH (TAG_WIDTH)
    ) u_front (
        .cfg      (cfg_reg),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .kind     (kind),
        .address  (address),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_kind   (push_kind),
        .q_set    (push_set),
        .q_tag    (push_tag)
    );

    // Work queue
    sac_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({push_kind, push_set, push_tag}),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    assign pop_kind = pop_data[Q_W-1];
    assign pop_set  = pop_data[TAG_WIDTH +: SET_W];
    assign pop_tag  = pop_data[TAG_WIDTH-1:0];

    // Back end: lookup, replacement and totals
    sac_back #(
        .SETS        (SETS),
        .WAYS        (WAYS),
        .TAG_WIDTH   (TAG_WIDTH),
        .STAMP_WIDTH (STAMP_WIDTH)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg               (cfg_reg),
        .seed_load         (seed_load),
        .seed_value        (cfg_data[LFSR_W-1:0]),
        .q_empty           (q_empty),
        .q_pop             (q_pop),
        .q_kind            (pop_kind),
        .q_set             (pop_set),
        .q_tag             (pop_tag),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .hit               (hit),
        .replaced          (replaced),
        .way               (way),
        .set_index         (set_index),
        .hit_count         (hit_count),
        .miss_count        (miss_count),
        .replacement_count (replacement_count)
    );

endmodule
